// ===== rtl/isaac_random_generator_top_defines.svh =====
// ----------------------------------------------------------------------------
// ISAAC generator assertion macros
// Shared assertion forms for the checker attached to the top level.
// ----------------------------------------------------------------------------
`ifndef ISAAC_RANDOM_GENERATOR_TOP_DEFINES_SVH
`define ISAAC_RANDOM_GENERATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define IRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irg port check failed");

// Consequent must hold in the cycle after the antecedent
`define IRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irg port check failed");

`endif

// ===== rtl/irg_pkg.sv =====
// ----------------------------------------------------------------------------
// ISAAC generator package
// Sizes, opcodes, the mixer command bundle and the shift helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package irg_pkg;

  // Memory geometry
  localparam int LOG2_WORDS = 8;
  localparam int WORDS      = 1 << LOG2_WORDS;
  localparam int IDX_W      = LOG2_WORDS;
  localparam int CNT_W      = LOG2_WORDS + 1;

  localparam logic [31:0] GOLDEN = 32'h9E37_79B9;

  // Opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INIT   = 2'd1;
  localparam logic [1:0] OP_DRAW   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [31:0] word_t;

  // Command to the eight-word mixer
  typedef struct packed {
    logic       load_golden;
    logic       step_en;
    logic [2:0] step_idx;
    logic       add_en;
    logic       rot_en;
  } mix_cmd_t;

  // Shift applied to the second word in each scramble step
  function automatic word_t scramble_shift(input logic [2:0] step, input word_t w);
    word_t r;
    unique case (step)
      3'd0: r = w << 11;
      3'd1: r = w >> 2;
      3'd2: r = w << 8;
      3'd3: r = w >> 16;
      3'd4: r = w << 10;
      3'd5: r = w >> 4;
      3'd6: r = w << 8;
      3'd7: r = w >> 9;
      default: r = w;
    endcase
    return r;
  endfunction

  // Accumulator shift used in the refill loop
  function automatic word_t refill_mix(input logic [1:0] phase, input word_t a);
    word_t r;
    unique case (phase)
      2'd0: r = a << 13;
      2'd1: r = a >> 6;
      2'd2: r = a << 2;
      2'd3: r = a >> 16;
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/isaac_random_generator_top.sv =====
// ----------------------------------------------------------------------------
// ISAAC random generator top level
// Seed loads, golden-ratio set-up and draws over a state memory and a
// result buffer, both synchronous RAMs with registered read data.
// ----------------------------------------------------------------------------
//  channel | ports                                               | handshake
//  input   | in_opcode, in_seed_index, in_seed_word, in_use_seed | start && !busy
//  result  | out_random_word                                     | out_valid strobe
//
//  Load: written at once, busy stays low. Draw with words left: result strobed the next cycle.
//  Draw with none left: a refill through states ST_R1 to ST_R5 for each word (one
//  state-memory read port, four reads and a write back per word).
//  Initialize: four warm-up scrambles, then per group of 8 words an add-in (seeded
//  only, 2 passes), a scramble and a write-back; then a refill.
//  Reset clears control state only; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module isaac_random_generator_top import irg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_seed_index,
  input  logic [31:0] in_seed_word,
  input  logic        in_use_seed,
  output logic        out_valid,
  output logic [31:0] out_random_word
);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WARM = 4'd1;
  localparam logic [3:0] ST_ADD  = 4'd2;
  localparam logic [3:0] ST_SCR  = 4'd3;
  localparam logic [3:0] ST_WR   = 4'd4;
  localparam logic [3:0] ST_RS   = 4'd5;
  localparam logic [3:0] ST_R1   = 4'd6;
  localparam logic [3:0] ST_R2   = 4'd7;
  localparam logic [3:0] ST_R3   = 4'd8;
  localparam logic [3:0] ST_R4   = 4'd9;
  localparam logic [3:0] ST_R5   = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(WORDS / 2);
  localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(WORDS - 1);
  localparam logic [IDX_W-1:0] LAST_GRP = IDX_W'(WORDS - 8);
  localparam logic [IDX_W-1:0] GRP_STEP = IDX_W'(8);

  logic [3:0]       state_r, state_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [IDX_W-1:0] fa_r, fa_nxt;
  logic             pass_r, pass_nxt;
  logic             seeded_r, seeded_nxt;
  logic             draw_r, draw_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  word_t            a_r, a_nxt;
  word_t            b_r, b_nxt;
  word_t            rc_r, rc_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W+7:0] seed_ext;
  word_t            y_new;
  word_t            b_new;

  // Memories
  word_t            smem [WORDS];
  word_t            rbuf [WORDS];
  word_t            smem_q, rbuf_q;
  logic             smem_re, smem_we, rbuf_re, rbuf_we;
  logic [IDX_W-1:0] smem_raddr, smem_waddr, rbuf_raddr, rbuf_waddr;
  word_t            smem_wdata, rbuf_wdata;

  // Mixer
  mix_cmd_t         mcmd;
  word_t            mix_add;
  word_t            mix_head;

  irg_mix u_irg_mix (
    .clk       (clk),
    .cmd       (mcmd),
    .add_data  (mix_add),
    .head_word (mix_head)
  );

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign cnt_dec  = count_r - CNT_W'(1);
  assign seed_ext = {{IDX_W{1'b0}}, in_seed_index};
  assign y_new    = smem_q + a_r + b_r;
  assign b_new    = smem_q + x_r;
  assign mix_add  = pass_r ? smem_q : rbuf_q;

  // Sequence loads, set-up passes, refills and draws
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    k_nxt         = k_r;
    fa_nxt        = fa_r;
    pass_nxt      = pass_r;
    seeded_nxt    = seeded_r;
    draw_nxt      = draw_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rc_nxt        = rc_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    smem_re       = 1'b0;
    smem_raddr    = idx_r;
    smem_we       = 1'b0;
    smem_waddr    = idx_r;
    smem_wdata    = y_new;
    rbuf_re       = 1'b0;
    rbuf_raddr    = cnt_dec[IDX_W-1:0];
    rbuf_we       = 1'b0;
    rbuf_waddr    = idx_r;
    rbuf_wdata    = b_new;
    mcmd          = '0;
    mcmd.step_idx = step_r[2:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            OP_LOAD: begin
              rbuf_we    = 1'b1;
              rbuf_waddr = seed_ext[IDX_W-1:0];
              rbuf_wdata = in_seed_word;
            end
            OP_INIT: begin
              a_nxt            = '0;
              b_nxt            = '0;
              rc_nxt           = '0;
              mcmd.load_golden = 1'b1;
              seeded_nxt       = in_use_seed;
              draw_nxt         = 1'b0;
              step_nxt         = '0;
              state_nxt        = ST_WARM;
            end
            OP_DRAW: begin
              if (count_r != '0) begin
                count_nxt     = cnt_dec;
                rbuf_re       = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                draw_nxt  = 1'b1;
                state_nxt = ST_RS;
              end
            end
            OP_UNUSED: begin
            end
            default: begin
            end
          endcase
        end
      end

      // Four warm-up scrambles, one step a cycle
      ST_WARM: begin
        mcmd.step_en = 1'b1;
        step_nxt     = step_r + 5'd1;
        if (step_r == 5'd31) begin
          fa_nxt    = '0;
          pass_nxt  = 1'b0;
          k_nxt     = '0;
          step_nxt  = '0;
          state_nxt = seeded_r ? ST_ADD : ST_SCR;
        end
      end

      // Add the group's source words, one read a cycle, each added in the next cycle
      ST_ADD: begin
        if (!k_r[3]) begin
          if (pass_r) begin
            smem_re    = 1'b1;
            smem_raddr = fa_r + IDX_W'(k_r[2:0]);
          end else begin
            rbuf_re    = 1'b1;
            rbuf_raddr = fa_r + IDX_W'(k_r[2:0]);
          end
        end
        mcmd.add_en = (k_r != '0);
        k_nxt       = k_r + 4'd1;
        if (k_r[3]) begin
          step_nxt  = '0;
          state_nxt = ST_SCR;
        end
      end

      // One scramble of the vector
      ST_SCR: begin
        mcmd.step_en = 1'b1;
        step_nxt     = step_r + 5'd1;
        if (step_r[2:0] == 3'd7) begin
          k_nxt     = '0;
          step_nxt  = '0;
          state_nxt = ST_WR;
        end
      end

      // Write the vector to the group, then advance group or pass
      ST_WR: begin
        smem_we     = 1'b1;
        smem_waddr  = fa_r + IDX_W'(k_r[2:0]);
        smem_wdata  = mix_head;
        mcmd.rot_en = 1'b1;
        k_nxt       = k_r + 4'd1;
        if (k_r[2:0] == 3'd7) begin
          k_nxt    = '0;
          step_nxt = '0;
          if (fa_r == LAST_GRP) begin
            if (seeded_r && !pass_r) begin
              pass_nxt  = 1'b1;
              fa_nxt    = '0;
              state_nxt = ST_ADD;
            end else begin
              state_nxt = ST_RS;
            end
          end else begin
            fa_nxt    = fa_r + GRP_STEP;
            state_nxt = seeded_r ? ST_ADD : ST_SCR;
          end
        end
      end

      // Refill start: bump the round counter, read the first word
      ST_RS: begin
        rc_nxt     = rc_r + 32'd1;
        b_nxt      = b_r + rc_r + 32'd1;
        idx_nxt    = '0;
        smem_re    = 1'b1;
        smem_raddr = '0;
        state_nxt  = ST_R1;
      end

      ST_R1: begin
        x_nxt      = smem_q;
        smem_re    = 1'b1;
        smem_raddr = idx_r ^ IDX_HALF;
        state_nxt  = ST_R2;
      end

      ST_R2: begin
        a_nxt      = (a_r ^ refill_mix(idx_r[1:0], a_r)) + smem_q;
        smem_re    = 1'b1;
        smem_raddr = x_r[IDX_W+1:2];
        state_nxt  = ST_R3;
      end

      // Write back the new state word
      ST_R3: begin
        y_nxt      = y_new;
        smem_we    = 1'b1;
        smem_waddr = idx_r;
        smem_wdata = y_new;
        state_nxt  = ST_R4;
      end

      ST_R4: begin
        smem_re    = 1'b1;
        smem_raddr = y_r[2*IDX_W+1:IDX_W+2];
        state_nxt  = ST_R5;
      end

      // Store the result word, then start the next index or end the refill
      ST_R5: begin
        b_nxt   = b_new;
        rbuf_we = 1'b1;
        if (idx_r == IDX_MAX) begin
          if (draw_r) begin
            count_nxt = CNT_W'(WORDS - 1);
            state_nxt = ST_OUT;
          end else begin
            count_nxt = CNT_W'(WORDS);
            state_nxt = ST_IDLE;
          end
        end else begin
          idx_nxt    = idx_r + IDX_W'(1);
          smem_re    = 1'b1;
          smem_raddr = idx_r + IDX_W'(1);
          state_nxt  = ST_R1;
        end
      end

      // Read the last result word for the pending draw
      ST_OUT: begin
        rbuf_re       = 1'b1;
        rbuf_raddr    = IDX_MAX;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      a_r         <= '0;
      b_r         <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    k_r      <= k_nxt;
    fa_r     <= fa_nxt;
    pass_r   <= pass_nxt;
    seeded_r <= seeded_nxt;
    draw_r   <= draw_nxt;
    idx_r    <= idx_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
  end

  // State memory
  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_waddr] <= smem_wdata;
    end
    if (smem_re) begin
      smem_q <= smem[smem_raddr];
    end
  end

  // Result buffer
  always_ff @(posedge clk) begin
    if (rbuf_we) begin
      rbuf[rbuf_waddr] <= rbuf_wdata;
    end
    if (rbuf_re) begin
      rbuf_q <= rbuf[rbuf_raddr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = rbuf_q;

endmodule

`default_nettype wire

// ===== rtl/irg_mix.sv =====
// ----------------------------------------------------------------------------
// ISAAC eight-word mixer
// Holds the set-up vector; one scramble step, add-in or rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_mix import irg_pkg::*; (
  input  logic     clk,
  input  mix_cmd_t cmd,
  input  word_t    add_data,
  output word_t    head_word
);

  word_t v_r   [8];
  word_t v_nxt [8];
  word_t w     [8];
  word_t t;

  // Work on fixed positions 0..3, then rotate so the next step sees its words there
  always_comb begin
    t = v_r[0] ^ scramble_shift(cmd.step_idx, v_r[1]);
    for (int k = 0; k < 8; k++) begin
      w[k]     = v_r[k];
      v_nxt[k] = v_r[k];
    end
    if (cmd.step_en) begin
      w[0] = t;
      w[3] = v_r[3] + t;
      w[1] = v_r[1] + v_r[2];
    end else if (cmd.add_en) begin
      w[0] = v_r[0] + add_data;
    end
    priority if (cmd.load_golden) begin
      for (int k = 0; k < 8; k++) begin
        v_nxt[k] = GOLDEN;
      end
    end else if (cmd.step_en || cmd.add_en || cmd.rot_en) begin
      for (int k = 0; k < 8; k++) begin
        v_nxt[k] = w[(k + 1) % 8];
      end
    end else begin
      // hold the vector
      for (int k = 0; k < 8; k++) begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      v_r[k] <= v_nxt[k];
    end
  end

  assign head_word = v_r[0];

endmodule

`default_nettype wire

// ===== rtl/irg_checker.sv =====
// ----------------------------------------------------------------------------
// ISAAC generator port checker
// Watches the top level's ports for beat ordering and busy behavior.
// ----------------------------------------------------------------------------
`default_nettype none
`include "isaac_random_generator_top_defines.svh"

module irg_checker import irg_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_opcode,
  input logic       out_valid
);

  // An initialize always occupies the block
  `IRG_ASSERT_NEXT(a_init_busy, start && !busy && in_opcode == OP_INIT, busy)

  // A seed load finishes at once and gives no beat
  `IRG_ASSERT_NEXT(a_load_quiet, start && !busy && in_opcode == OP_LOAD, !busy && !out_valid)

  // The unused opcode does nothing
  `IRG_ASSERT_NEXT(a_unused_quiet, start && !busy && in_opcode == OP_UNUSED, !busy && !out_valid)

  // A result beat follows a draw or the end of a refill
  `IRG_ASSERT_NOW(a_out_source, out_valid, $past(busy) || $past(in_opcode) == OP_DRAW)

endmodule

bind isaac_random_generator_top irg_checker u_irg_checker (.*);

`default_nettype wire

// ===== verif/isaac_random_generator_checker.sv =====
// ----------------------------------------------------------------------------
// ISAAC random generator checker
// Watches the command and result channels of the generator. It keeps its own
// copy of the state memory, result buffer and accumulators, predicts the word
// returned by every accepted draw and compares each strobed result against
// the oldest predicted word.
// ----------------------------------------------------------------------------
module isaac_random_generator_checker import irg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_seed_index,
  input  logic [31:0] in_seed_word,
  input  logic        in_use_seed,
  input  logic        out_valid,
  input  logic [31:0] out_random_word,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // Predicted generator state
  word_t            state_mem  [WORDS];
  word_t            result_buf [WORDS];
  word_t            acc_a;
  word_t            last_b;
  word_t            round_cnt;
  logic [CNT_W-1:0] words_left;
  word_t            mix_reg [8];

  // Words owed by accepted draws, oldest first
  word_t words_due [$];
  int    fail_cnt;

  // One round of the eight-word golden-ratio mixer
  function void stir_mix();
    mix_reg[0] ^= mix_reg[1] << 11; mix_reg[3] += mix_reg[0]; mix_reg[1] += mix_reg[2];
    mix_reg[1] ^= mix_reg[2] >> 2;  mix_reg[4] += mix_reg[1]; mix_reg[2] += mix_reg[3];
    mix_reg[2] ^= mix_reg[3] << 8;  mix_reg[5] += mix_reg[2]; mix_reg[3] += mix_reg[4];
    mix_reg[3] ^= mix_reg[4] >> 16; mix_reg[6] += mix_reg[3]; mix_reg[4] += mix_reg[5];
    mix_reg[4] ^= mix_reg[5] << 10; mix_reg[7] += mix_reg[4]; mix_reg[5] += mix_reg[6];
    mix_reg[5] ^= mix_reg[6] >> 4;  mix_reg[0] += mix_reg[5]; mix_reg[6] += mix_reg[7];
    mix_reg[6] ^= mix_reg[7] << 8;  mix_reg[1] += mix_reg[6]; mix_reg[7] += mix_reg[0];
    mix_reg[7] ^= mix_reg[0] >> 9;  mix_reg[2] += mix_reg[7]; mix_reg[0] += mix_reg[1];
  endfunction

  // Walk the state memory once, producing a fresh result buffer
  function void regen_results();
    word_t a;
    word_t b;
    word_t x;
    word_t y;
    word_t sh;
    a = acc_a;
    round_cnt = round_cnt + 1;
    b = last_b + round_cnt;
    for (int i = 0; i < WORDS; i++) begin
      x = state_mem[i];
      case (i % 4)
        0:       sh = a << 13;
        1:       sh = a >> 6;
        2:       sh = a << 2;
        default: sh = a >> 16;
      endcase
      a = (a ^ sh) + state_mem[(i + WORDS / 2) % WORDS];
      y = state_mem[(x >> 2) % WORDS] + a + b;
      state_mem[i] = y;
      b = state_mem[(y >> (LOG2_WORDS + 2)) % WORDS] + x;
      result_buf[i] = b;
    end
    acc_a  = a;
    last_b = b;
  endfunction

  // Seed the state memory in groups of eight, optionally adding a source in
  function void fill_state(input bit add_results, input bit add_state);
    for (int i = 0; i < WORDS; i += 8) begin
      for (int k = 0; k < 8; k++) begin
        if (add_results) mix_reg[k] += result_buf[i + k];
        if (add_state)   mix_reg[k] += state_mem[i + k];
      end
      stir_mix();
      for (int k = 0; k < 8; k++) state_mem[i + k] = mix_reg[k];
    end
  endfunction

  function void set_up(input logic seeded);
    acc_a     = '0;
    last_b    = '0;
    round_cnt = '0;
    for (int k = 0; k < 8; k++) mix_reg[k] = GOLDEN;
    for (int k = 0; k < 4; k++) stir_mix();
    if (seeded) begin
      fill_state(1'b1, 1'b0);
      fill_state(1'b0, 1'b1);
    end else begin
      fill_state(1'b0, 1'b0);
    end
    regen_results();
    words_left = CNT_W'(WORDS);
  endfunction

  // Count down; refill first when nothing is left
  function void draw_word();
    if (words_left == '0) begin
      regen_results();
      words_left = CNT_W'(WORDS - 1);
    end else begin
      words_left = words_left - 1'b1;
    end
    words_due.push_back(result_buf[int'(words_left) % WORDS]);
  endfunction

  // Predict on accepted commands, then check strobed results
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_a      = '0;
      last_b     = '0;
      round_cnt  = '0;
      words_left = '0;
      for (int i = 0; i < WORDS; i++) begin
        state_mem[i]  = '0;
        result_buf[i] = '0;
      end
    end else begin
      if (start && !busy) begin
        case (in_opcode)
          OP_LOAD: result_buf[int'(in_seed_index) % WORDS] = in_seed_word;
          OP_INIT: set_up(in_use_seed);
          OP_DRAW: draw_word();
          default: ;
        endcase
      end
      if (out_valid) begin
        if (words_due.size() == 0) begin
          if (fail_cnt < REPORT_MAX)
            $display("%0t: random_word %h strobed with no draw outstanding",
                     $realtime, out_random_word);
          fail_cnt++;
        end else begin
          if (out_random_word !== words_due[0]) begin
            if (fail_cnt < REPORT_MAX)
              $display("%0t: random_word mismatch: expected %h, got %h",
                       $realtime, words_due[0], out_random_word);
            fail_cnt++;
          end
          void'(words_due.pop_front());
        end
      end
    end
    pending    <= words_due.size();
    mismatches <= fail_cnt;
  end

endmodule

// ===== verif/isaac_random_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// ISAAC random generator testbench
// Drives seed loads, initializations and draws into the generator: a short
// directed sequence, then random sessions of loads, an initialize and runs
// of draws, some crossing refill boundaries, with noise commands mixed in
// and the sender pausing at varying rates. The checker beside the block
// predicts every drawn word; this module gives the verdict.
// ----------------------------------------------------------------------------
module isaac_random_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import irg_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 11;
  localparam int ITEM_TARGET = 1250;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_UNUSED;
  logic [7:0]  in_seed_index = '0;
  logic [31:0] in_seed_word = '0;
  logic        in_use_seed = 1'b0;
  logic        out_valid;
  logic [31:0] out_random_word;

  int mismatches;
  int pending;

  // Stimulus bookkeeping: which buffer words hold known values
  logic [WORDS-1:0] loaded_mask = '0;
  int               items_sent = 0;
  int               idle_pct = 0;
  int               quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  isaac_random_generator_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_seed_index   (in_seed_index),
    .in_seed_word    (in_seed_word),
    .in_use_seed     (in_use_seed),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  isaac_random_generator_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_seed_index   (in_seed_index),
    .in_seed_word    (in_seed_word),
    .in_use_seed     (in_use_seed),
    .out_valid       (out_valid),
    .out_random_word (out_random_word),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Send one command beat; returns after the accepting edge once busy is low
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] idx,
                          input word_t word, input logic seeded);
    if (items_sent % PHASE_ITEMS == 0) begin
      case ((items_sent / PHASE_ITEMS) % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 55;
        2:       idle_pct = 0;
        default: idle_pct = 26;
      endcase
    end
    // hold off the sender, with noise on the idle command fields
    while ($urandom_range(99) < idle_pct) begin
      start         <= 1'b0;
      in_opcode     <= 2'($urandom);
      in_seed_index <= 8'($urandom);
      in_seed_word  <= $urandom;
      in_use_seed   <= 1'($urandom);
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_seed_index <= idx;
    in_seed_word  <= word;
    in_use_seed   <= seeded;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    if (op == OP_LOAD) loaded_mask[int'(idx) % WORDS] = 1'b1;
    if (op == OP_INIT) begin
      loaded_mask = '1;
    end
  endtask

  task automatic send_draws(input int count);
    int r;
    for (int n = 0; n < count && items_sent < ITEM_TARGET; n++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_cmd(OP_LOAD, 8'($urandom), $urandom, 1'($urandom));
      end else if (r < 10) begin
        send_cmd(OP_UNUSED, 8'($urandom), $urandom, 1'($urandom));
      end
      send_cmd(OP_DRAW, 8'($urandom), $urandom, 1'($urandom));
    end
  endtask

  initial begin
    int base;
    int draws;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused opcode before set-up, extreme loads, both set-ups
    send_cmd(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_LOAD, 8'h00, 32'h0000_0000, 1'b0);
    send_cmd(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_LOAD, 8'h55, 32'hAAAA_AAAA, 1'b0);
    send_cmd(OP_INIT, 8'h00, 32'h0000_0000, 1'b0);
    repeat (4) send_cmd(OP_DRAW, 8'h00, 32'h0000_0000, 1'b0);
    // overwrite the word the next draw returns
    send_cmd(OP_LOAD, 8'd251, 32'hFFFF_FFFF, 1'b0);
    send_cmd(OP_DRAW, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_cmd(OP_INIT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    repeat (3) send_cmd(OP_DRAW, 8'h00, 32'h0000_0000, 1'b0);
    send_cmd(OP_UNUSED, 8'h00, 32'h0000_0000, 1'b0);
    send_cmd(OP_DRAW, 8'h00, 32'h0000_0000, 1'b0);
    send_cmd(OP_INIT, 8'h00, 32'h0000_0000, 1'b0);
    send_cmd(OP_DRAW, 8'h00, 32'h0000_0000, 1'b0);

    // Full seed load from a random offset, seeded set-up, two refills deep
    base = $urandom_range(WORDS - 1);
    for (int k = 0; k < WORDS; k++)
      send_cmd(OP_LOAD, 8'((base + k) % WORDS), $urandom, 1'($urandom));
    send_cmd(OP_INIT, 8'($urandom), $urandom, 1'b1);
    send_draws($urandom_range(2 * WORDS + 8, 2 * WORDS + 80));

    // Random sessions: a few loads, a set-up, a run of draws
    while (items_sent < ITEM_TARGET) begin
      repeat ($urandom_range(8)) send_cmd(OP_LOAD, 8'($urandom), $urandom, 1'($urandom));
      send_cmd(OP_INIT, 8'($urandom), $urandom,
               (&loaded_mask) ? 1'($urandom) : 1'b0);
      if ($urandom_range(1)) draws = $urandom_range(20, WORDS - 56);
      else draws = $urandom_range(WORDS + 1, 2 * WORDS + 40);
      send_draws(draws);
    end
    start <= 1'b0;

    // Drain outstanding words, then leave room for strays
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
